### rtl/cfq_pkg.sv
// Shared types, codes and constants of the circular FIFO queue.
package cfq_pkg;

  // Default ring storage depth.
  localparam int CFQ_DEPTH = 16;

  // Widths of the fields and of the register port.
  localparam int WORD_W = 32;
  localparam int CMD_W = 2;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 5;
  localparam int APB_DW = 32;
  localparam int APB_AW = 2;

  // Register addresses.
  localparam logic [APB_AW-1:0] ADDR_SLOTS_IN_USE = '0;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic load_read;
    logic next_read;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read;
    logic no_result;
    logic more;
  } dp_stat_t;

endpackage

### rtl/cfq_ctrl.sv
// Controller state machine of the circular FIFO queue.
module cfq_ctrl
  import cfq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    dp_cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.take_item = 1'b1;
          if (dp_stat.no_result) begin
            state_next = ST_IDLE;
          end else if (dp_stat.needs_read) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_READ: begin
        dp_cmd.load_read = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (dp_stat.more) begin
            dp_cmd.next_read = 1'b1;
            state_next = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/cfq_datapath.sv
// Datapath of the circular FIFO queue: ring indices, slot memory and result register.
module cfq_datapath
  import cfq_pkg::*;
#(
  parameter int DEPTH = CFQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [WORD_W-1:0] value,
  input  logic                     cfg_wr,
  input  logic [SLOT_W-1:0]        cfg_data,
  output logic [SLOT_W-1:0]        slots_in_use,
  input  dp_cmd_t                  dp_cmd,
  output dp_stat_t                 dp_stat,
  output logic [STAT_W-1:0]        status,
  output logic signed [WORD_W-1:0] data,
  output logic                     last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (IDX_W + 1 > SLOT_W) ? IDX_W + 1 : SLOT_W;
  localparam int SLOT_MAX_I = (DEPTH < 31) ? DEPTH : 31;
  localparam int SLOT_RST_I = (DEPTH < 16) ? DEPTH : 16;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOT_MAX_I);
  localparam logic [SLOT_W-1:0] SLOT_RST = SLOT_W'(SLOT_RST_I);
  localparam logic [SLOT_W-1:0] SLOT_MIN = SLOT_W'(2);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [IDX_W-1:0]  cursor;
  logic              dumping;

  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  tail_inc;
  logic [IDX_W-1:0]  cursor_inc;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic              empty;
  logic              full;
  logic [SLOT_W-1:0] slot_sat;

  // Step an index round the ring, wrapping at the configured size.
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                 input logic [SLOT_W-1:0] size);
    logic [CMP_W-1:0] inc;
    inc = CMP_W'(idx) + CMP_W'(1);
    return (inc >= CMP_W'(size)) ? '0 : inc[IDX_W-1:0];
  endfunction

  assign head_inc = ring_next(head, slots_in_use);
  assign tail_inc = ring_next(tail, slots_in_use);
  assign cursor_inc = ring_next(cursor, slots_in_use);
  assign empty = (head == tail);
  assign full = (tail_inc == head);

  // Saturate a written ring size into the supported range.
  always_comb begin
    if (cfg_data < SLOT_MIN) begin
      slot_sat = SLOT_MIN;
    end else if (cfg_data > SLOT_MAX) begin
      slot_sat = SLOT_MAX;
    end else begin
      slot_sat = cfg_data;
    end
  end

  // Status for the controller, decoded from the offered command.
  always_comb begin
    dp_stat.needs_read = 1'b0;
    dp_stat.no_result = 1'b0;
    unique case (cmd)
      CMD_ENQ: dp_stat.needs_read = 1'b0;
      CMD_DEQ, CMD_DUMP: dp_stat.needs_read = !empty;
      CMD_NONE: dp_stat.no_result = 1'b1;
      default: dp_stat.no_result = 1'b1;
    endcase
    dp_stat.more = dumping && (cursor != tail);
  end

  // Memory read address: the oldest entry on a new request, else the next dump entry.
  always_comb begin
    rd_en = 1'b0;
    rd_addr = head_inc;
    if (dp_cmd.take_item && dp_stat.needs_read) begin
      rd_en = 1'b1;
    end else if (dp_cmd.next_read) begin
      rd_en = 1'b1;
      rd_addr = cursor_inc;
    end
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk) begin
    if (dp_cmd.take_item && cmd == CMD_ENQ && !full) begin
      mem[tail_inc] <= value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Ring indices, ring size and dump tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cursor <= '0;
      dumping <= 1'b0;
      slots_in_use <= SLOT_RST;
    end else if (cfg_wr) begin
      head <= '0;
      tail <= '0;
      slots_in_use <= slot_sat;
    end else if (dp_cmd.take_item) begin
      case (cmd)
        CMD_ENQ: begin
          if (!full) begin
            tail <= tail_inc;
          end
          dumping <= 1'b0;
        end
        CMD_DEQ: begin
          if (!empty) begin
            head <= head_inc;
          end
          dumping <= 1'b0;
        end
        CMD_DUMP: begin
          cursor <= head_inc;
          dumping <= !empty;
        end
        default: begin
          dumping <= 1'b0;
        end
      endcase
    end else if (dp_cmd.next_read) begin
      cursor <= cursor_inc;
    end
  end

  // Result register: loaded directly for enqueues and empty requests, from memory otherwise.
  always_ff @(posedge clk) begin
    if (dp_cmd.take_item) begin
      last <= 1'b1;
      case (cmd)
        CMD_ENQ: begin
          status <= full ? STAT_FULL : STAT_OK;
          data <= full ? '0 : value;
        end
        default: begin
          status <= STAT_EMPTY;
          data <= '0;
        end
      endcase
    end else if (dp_cmd.load_read) begin
      status <= STAT_OK;
      data <= rdata;
      last <= !dumping || (cursor == tail);
    end
  end

endmodule

### rtl/circular_fifo_queue.sv
// Top level of the circular FIFO queue: register port, controller and datapath.
//
// A ring-buffer queue of signed 32-bit words with a ring of slots_in_use slots,
// of which one always stays free. Requests arrive on the input channel
// (in_valid/in_ready, fields cmd and value); results leave on the output
// channel (out_valid/out_ready, fields status, data and last).
// Enqueue presents its result in the cycle after acceptance. A dequeue result
// passes first through the registered read of the slot memory and then the
// result register; an empty dequeue or dump behaves like an enqueue. A dump
// gives one result per stored word, each read from the slot memory, with last
// set on the newest word. One request is in flight at a time: the next is
// accepted in the cycle after the final result of the previous one is taken.
// When the receiver stalls, the result is held in the output register and no
// new request is accepted. Reset empties the queue and sets the ring size to
// sixteen slots (or the depth, if smaller); writing slots_in_use over the
// register port also empties the queue and must only be done while idle.
module circular_fifo_queue
  import cfq_pkg::*;
#(
  parameter int DEPTH = CFQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [WORD_W-1:0] data,
  output logic                     last,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;
  logic              cfg_wr;
  logic [SLOT_W-1:0] slots_in_use;

  // Register port: a single register, read at address zero; a write to any address sets it.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_SLOTS_IN_USE) begin
      prdata = {{(APB_DW - SLOT_W){1'b0}}, slots_in_use};
    end
  end

  cfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  cfq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .cfg_wr       (cfg_wr),
    .cfg_data     (pwdata[SLOT_W-1:0]),
    .slots_in_use (slots_in_use),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat),
    .status       (status),
    .data         (data),
    .last         (last)
  );

endmodule
